// ===== hw/rtl/lzwc_pkg.sv =====
// Shared types and constants for the LZ77 window copy decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lzwc_pkg;

    localparam int MAX_RESULTS = 64;  // bytes emitted per match token, at most
    localparam int CNT_W       = 31;  // produced count and register width
    localparam int LEN_W       = 7;   // remaining-byte counter, holds MAX_RESULTS
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_STREAM_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 1'd1;

    typedef enum logic [1:0] {
        JOB_RUNNING = 2'd0,
        JOB_DONE    = 2'd1,
        JOB_ERROR   = 2'd2
    } job_status_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECIDE = 2'd1,
        ST_COPY   = 2'd2
    } ctl_state_t;

    typedef struct packed {
        logic        is_match;
        logic [7:0]  literal_byte;
        logic [14:0] distance_code;
        logic [7:0]  length_code;
    } token_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
        logic       done_res;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic drop_done;
        logic emit_lit;
        logic emit_err;
        logic start_copy;
        logic copy_step;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic running;
        logic reached;
        logic cap_full;
        logic is_match;
        logic dist_bad;
        logic last_byte;
        logic slot_free;
    } dp_stat_t;

endpackage

// ===== hw/rtl/lzwc_ctrl.sv =====
// Token sequencer for the LZ77 window copy decoder.
// Depends on lzwc_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps

module lzwc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  lzwc_pkg::dp_stat_t stat,
    output lzwc_pkg::dp_cmd_t  cmd,
    output logic             in_stall,
    output logic             cfg_ready
);
    import lzwc_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.running || stat.reached)
                begin
                    state_next = ST_IDLE;
                end
                else if (!stat.is_match || stat.dist_bad)
                begin
                    if (stat.slot_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (stat.slot_free && (stat.cap_full || stat.last_byte))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        cfg_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cfg_ready  = 1'b1;
                cmd.accept = in_valid;
            end
            ST_DECIDE:
            begin
                if (!stat.running)
                begin
                    cmd = '0;
                end
                else if (stat.reached)
                begin
                    cmd.drop_done = 1'b1;
                end
                else if (!stat.is_match)
                begin
                    cmd.emit_err = stat.slot_free && stat.cap_full;
                    cmd.emit_lit = stat.slot_free && !stat.cap_full;
                end
                else if (stat.dist_bad)
                begin
                    cmd.emit_err = stat.slot_free;
                end
                else
                begin
                    cmd.start_copy = 1'b1;
                end
            end
            ST_COPY:
            begin
                cmd.emit_err  = stat.slot_free && stat.cap_full;
                cmd.copy_step = stat.slot_free && !stat.cap_full;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lzwc_datapath.sv =====
// Datapath of the LZ77 window copy decoder: registers, counters,
// history ring memory and output register. Depends on lzwc_pkg.
`timescale 1ns / 1ps

module lzwc_datapath
#(
    parameter int WINDOW_BYTES = 32768,
    parameter int MIN_MATCH    = 3
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lzwc_pkg::token_t                  in_data,
    input  logic                              cfg_we,
    input  logic [lzwc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lzwc_pkg::CNT_W-1:0]        cfg_data,
    input  lzwc_pkg::dp_cmd_t                 cmd,
    output lzwc_pkg::dp_stat_t                stat,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lzwc_pkg::result_t                 out_data
);
    import lzwc_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_BYTES - 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == PTR_LAST) ? '0 : p + AW'(1);
        return r;
    endfunction

    logic [7:0] ring_mem [WINDOW_BYTES];

    logic [CNT_W-1:0] stream_length_reg;
    logic [CNT_W-1:0] output_capacity_reg;
    logic [CNT_W-1:0] count_reg,     count_next;
    job_status_t      status_reg,    status_next;
    logic [AW-1:0]    wptr_reg,      wptr_next;
    logic [AW-1:0]    rptr_reg,      rptr_next;
    logic [LEN_W-1:0] remaining_reg, remaining_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg,  out_data_next;
    token_t           tok_reg;
    logic [7:0]       rd_data_reg;
    logic             fwd_hit_reg;
    logic [7:0]       fwd_data_reg;

    logic [15:0]      distance;
    logic [8:0]       len_full;
    logic [LEN_W-1:0] len_sat;
    logic [31:0]      rptr_wide;
    logic [AW-1:0]    rptr_init;
    logic [CNT_W-1:0] count_inc;
    logic             reach_inc;
    logic [7:0]       copy_byte;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    assign distance  = 16'(tok_reg.distance_code) + 16'd1;
    assign len_full  = 9'(tok_reg.length_code) + 9'(MIN_MATCH);
    assign len_sat   = (len_full > 9'(MAX_RESULTS)) ? LEN_W'(MAX_RESULTS) : LEN_W'(len_full);
    // (wptr - distance) mod window; distance never exceeds the window on this path
    assign rptr_wide = 32'(wptr_reg) - 32'(distance)
                     + ((32'(wptr_reg) < 32'(distance)) ? 32'(WINDOW_BYTES) : 32'd0);
    assign rptr_init = rptr_wide[AW-1:0];
    assign count_inc = count_reg + CNT_W'(1);
    assign reach_inc = (count_inc >= stream_length_reg);
    assign copy_byte = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    assign stat.running   = (status_reg == JOB_RUNNING);
    assign stat.reached   = (count_reg >= stream_length_reg);
    assign stat.cap_full  = (count_reg >= output_capacity_reg);
    assign stat.is_match  = tok_reg.is_match;
    assign stat.dist_bad  = (32'(distance) > 32'(count_reg))
                         || (32'(distance) > 32'(WINDOW_BYTES));
    assign stat.last_byte = (remaining_reg == LEN_W'(1));
    assign stat.slot_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        remaining_next = remaining_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_data        = copy_byte;
        rd_en          = 1'b0;
        rd_addr        = rptr_reg;

        if (cmd.drop_done)
        begin
            status_next = JOB_DONE;
        end
        if (cmd.emit_err)
        begin
            status_next    = JOB_ERROR;
            out_valid_next = 1'b1;
            out_data_next  = '{out_byte: 8'd0, last: 1'b1, error: 1'b1, done_res: 1'b0};
        end
        if (cmd.emit_lit)
        begin
            wr_en          = 1'b1;
            wr_data        = tok_reg.literal_byte;
            count_next     = count_inc;
            wptr_next      = ptr_inc(wptr_reg);
            status_next    = reach_inc ? JOB_DONE : status_reg;
            out_valid_next = 1'b1;
            out_data_next  = '{out_byte: tok_reg.literal_byte, last: 1'b1,
                               error: 1'b0, done_res: reach_inc};
        end
        if (cmd.start_copy)
        begin
            rd_en          = 1'b1;
            rd_addr        = rptr_init;
            rptr_next      = ptr_inc(rptr_init);
            remaining_next = len_sat;
        end
        if (cmd.copy_step)
        begin
            wr_en          = 1'b1;
            count_next     = count_inc;
            wptr_next      = ptr_inc(wptr_reg);
            remaining_next = remaining_reg - LEN_W'(1);
            out_valid_next = 1'b1;
            out_data_next  = '{out_byte: copy_byte, last: stat.last_byte,
                               error: 1'b0, done_res: reach_inc};
            if (stat.last_byte)
            begin
                status_next = reach_inc ? JOB_DONE : status_reg;
            end
            else
            begin
                rd_en     = 1'b1;
                rptr_next = ptr_inc(rptr_reg);
            end
        end
        // writing the stream length restarts the job
        if (cfg_we && (cfg_index == REG_STREAM_LENGTH))
        begin
            count_next  = '0;
            wptr_next   = '0;
            status_next = JOB_RUNNING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg   <= '0;
            output_capacity_reg <= '1;
            count_reg           <= '0;
            status_reg          <= JOB_RUNNING;
            wptr_reg            <= '0;
            rptr_reg            <= '0;
            remaining_reg       <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            status_reg    <= status_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STREAM_LENGTH:
                    begin
                        stream_length_reg <= cfg_data;
                    end
                    REG_OUTPUT_CAPACITY:
                    begin
                        output_capacity_reg <= cfg_data;
                    end
                    default:
                    begin
                        output_capacity_reg <= output_capacity_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (cmd.accept)
        begin
            tok_reg <= in_data;
        end
    end

    // history ring; distance one reads the byte written in the same cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wptr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= ring_mem[rd_addr];
            fwd_hit_reg  <= wr_en && (wptr_reg == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/lz77_window_copy_decoder_top.sv =====
// Top level of the LZ77 window copy decoder.
// Depends on lzwc_pkg, lzwc_ctrl and lzwc_datapath.
`timescale 1ns / 1ps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid / in_stall    | in_data  (token_t)
//  out     | output    | out_valid / out_stall  | out_data (result_t)
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data (31 bit)
//
//  The token is taken in the idle state and checked in the decide state; unless
//  the job is already over, a literal or an error result then leaves, or a match
//  streams length bytes (saturated at 64) at one byte per cycle while out is not
//  stalled, paced by the single read port of the history ring.
//  Reset clears counters, status and the output valid flag; the ring needs no
//  clearing pass, legal distances only reach bytes of the current job.
//  A stall on out freezes the copy in place; in is stalled while a token is worked.

module lz77_window_copy_decoder_top
#(
    parameter int WINDOW_BYTES = 32768,
    parameter int MIN_MATCH    = 3
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  lzwc_pkg::token_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output lzwc_pkg::result_t               out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lzwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lzwc_pkg::CNT_W-1:0]      cfg_data
);
    import lzwc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     cfg_we;

    // config transaction completes on valid & ready; ready only while idle
    assign cfg_we = cfg_valid && cfg_ready;

    lzwc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready)
    );

    lzwc_datapath
    #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .MIN_MATCH    (MIN_MATCH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/lzwc_checker.sv =====
// Port-level checks for the LZ77 window copy decoder, bound to the top level.
// Depends on lzwc_pkg and lz77_window_copy_decoder_top.
`timescale 1ns / 1ps

module lzwc_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input lzwc_pkg::result_t               out_data,
    input logic                            cfg_ready
);
    import lzwc_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // error result carries no byte and ends its token
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |->
            out_data.last && !out_data.done_res && (out_data.out_byte == 8'd0))
        else $error("malformed error result");

    // a taken token keeps the block busy for its check cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !cfg_ready)
        else $error("token taken back to back");

    // nothing follows an error result right away
    a_quiet_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.error |=> !out_valid)
        else $error("result right after error");

endmodule

bind lz77_window_copy_decoder_top lzwc_checker u_lzwc_checker (.*);
